// ----- design/gab_pkg.sv -----
// ----------------------------------------------------------------------------
// gab_pkg
// Shared constants, types and weight table of the adaptive binarizer.
// ----------------------------------------------------------------------------
package gab_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int MIN_SIDE    = 8;
  localparam int RESET_SIDE  = 512;
  localparam int WINDOW      = 15;
  localparam int HALF        = WINDOW / 2;
  localparam int STORE_DEPTH = WINDOW * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SIDE_W      = 10;
  localparam int POS_W       = 9;
  localparam int PIX_W       = 8;
  localparam int CNT_W       = 19;
  localparam int EMIT_W      = 18;
  localparam int LAG_W       = 12;
  localparam int KIDX_W      = 4;
  localparam int WT_W        = 11;
  localparam int ROW_W       = 23;
  localparam int SUM_W       = 27;
  localparam int CFG_IDX_W   = 2;
  localparam int WT_TAB_BITS = (1 << (2 * KIDX_W)) * WT_W;

  localparam logic [PIX_W-1:0] WHITE = 8'd235;
  localparam logic [PIX_W-1:0] BLACK = 8'd16;

  localparam logic KIND_PIXEL = 1'b0;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } gab_state_t;

  // tap position travelling with a read
  typedef struct packed {
    logic              valid;
    logic [KIDX_W-1:0] ky;
    logic [KIDX_W-1:0] kx;
  } tap_tag_t;

  // position of the output pixel in the frame
  typedef struct packed {
    logic [POS_W-1:0]  row_pos;
    logic [POS_W-1:0]  col_pos;
    logic [SIDE_W-1:0] rem_rows;
    logic [SIDE_W-1:0] rem_cols;
    logic [SIDE_W-1:0] w_eff;
    logic [ADDR_W-1:0] base;
  } geom_t;

  // finished window sum
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] centre;
  } wsum_t;

  function automatic int unsigned gauss_tap(input int d);
    case (d)
      0:       return 8715;
      1:       return 8244;
      2:       return 6978;
      3:       return 5286;
      4:       return 3583;
      5:       return 2173;
      6:       return 1179;
      7:       return 573;
      8:       return 249;
      9:       return 97;
      10:      return 34;
      11:      return 10;
      12:      return 3;
      13:      return 1;
      default: return 0;
    endcase
  endfunction

  // 2-D weights, row-major with a stride of 16
  function automatic logic [WT_TAB_BITS-1:0] build_weights();
    logic [WT_TAB_BITS-1:0] tab;
    int unsigned p;
    int ay;
    int ax;
    tab = '0;
    for (int ky = 0; ky < WINDOW; ky++) begin
      for (int kx = 0; kx < WINDOW; kx++) begin
        ay = (ky > HALF) ? ky - HALF : HALF - ky;
        ax = (kx > HALF) ? kx - HALF : HALF - kx;
        p  = (gauss_tap(ay) * gauss_tap(ax) + 32768) >> 16;
        tab[(ky * (1 << KIDX_W) + kx) * WT_W +: WT_W] = WT_W'(p);
      end
    end
    return tab;
  endfunction

  localparam logic [WT_TAB_BITS-1:0] WEIGHT_TAB = build_weights();

  function automatic logic [WT_W-1:0] weight_at(input logic [2*KIDX_W-1:0] idx);
    return WEIGHT_TAB[idx * WT_W +: WT_W];
  endfunction

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                   input logic [SIDE_W-1:0] hi);
    if (v < SIDE_W'(MIN_SIDE)) return SIDE_W'(MIN_SIDE);
    if (v > hi) return hi;
    return v;
  endfunction

  // offset of the mirrored index from the centre, edge not repeated
  function automatic logic signed [4:0] mirror_off(input logic signed [4:0] d,
                                                   input logic [SIDE_W-1:0] lo,
                                                   input logic [SIDE_W-1:0] hi);
    logic signed [SIDE_W+1:0] dd;
    logic signed [SIDE_W+1:0] l;
    logic signed [SIDE_W+1:0] h;
    logic signed [SIDE_W+1:0] res;
    dd = d;
    l  = {2'b00, lo};
    h  = {2'b00, hi};
    if (dd + l < 0) begin
      res = -(l <<< 1) - dd;
    end else if (dd > h) begin
      res = (h <<< 1) - dd;
    end else begin
      res = dd;
    end
    return res[4:0];
  endfunction

endpackage

// ----- design/gab_pixel_if.sv -----
// ----------------------------------------------------------------------------
// gab_pixel_if
// Input channel: luma pixels and flush ticks.
// ----------------------------------------------------------------------------
interface gab_pixel_if;
  import gab_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] luma;

  modport source (output valid, output kind, output luma, input ready);
  modport sink   (input valid, input kind, input luma, output ready);
endinterface

// ----- design/gab_level_if.sv -----
// ----------------------------------------------------------------------------
// gab_level_if
// Output channel: binarized level and end-of-frame mark.
// ----------------------------------------------------------------------------
interface gab_level_if;
  import gab_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] level;
  logic             frame_end;

  modport source (output valid, output level, output frame_end, input ready);
  modport sink   (input valid, input level, input frame_end, output ready);
endinterface

// ----- design/gab_line_store.sv -----
// ----------------------------------------------------------------------------
// gab_line_store
// Circular pixel store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gab_line_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [gab_pkg::ADDR_W-1:0] waddr,
  input  logic [gab_pkg::PIX_W-1:0]  wdata,
  input  logic [gab_pkg::ADDR_W-1:0] raddr,
  output logic [gab_pkg::PIX_W-1:0]  rdata
);
  import gab_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ----- design/gab_tap_addr.sv -----
// ----------------------------------------------------------------------------
// gab_tap_addr
// Turns a tap position into a store address: mirror, offset, wrap.
// ----------------------------------------------------------------------------
module gab_tap_addr (
  input  logic                       clk,
  input  logic                       rst,
  input  gab_pkg::tap_tag_t          tag_in,
  input  gab_pkg::geom_t             geom,
  output gab_pkg::tap_tag_t          tag_out,
  output logic [gab_pkg::ADDR_W-1:0] addr
);
  import gab_pkg::*;

  localparam logic signed [ADDR_W+1:0] DEPTH_S = (ADDR_W+2)'(STORE_DEPTH);

  logic signed [4:0]        dy;
  logic signed [4:0]        dx;
  logic signed [4:0]        drow;
  logic signed [4:0]        dcol;
  logic signed [SIDE_W:0]   w_s;
  logic signed [15:0]       off_full;
  logic signed [ADDR_W-1:0] off_q;
  logic signed [ADDR_W+1:0] pos;
  logic signed [ADDR_W+1:0] wrapped;
  tap_tag_t                 tag1;
  tap_tag_t                 tag2;

  assign dy  = 5'(tag_in.ky) - 5'(HALF);
  assign dx  = 5'(tag_in.kx) - 5'(HALF);
  assign w_s = {1'b0, geom.w_eff};

  // stage 1: mirrored row and column offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else begin
      tag1.valid <= tag_in.valid;
    end
    tag1.ky <= tag_in.ky;
    tag1.kx <= tag_in.kx;
    drow    <= mirror_off(dy, {1'b0, geom.row_pos}, geom.rem_rows);
    dcol    <= mirror_off(dx, {1'b0, geom.col_pos}, geom.rem_cols);
  end

  // stage 2: linear offset from the centre pixel
  assign off_full = drow * w_s + dcol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2.valid <= 1'b0;
    end else begin
      tag2.valid <= tag1.valid;
    end
    tag2.ky <= tag1.ky;
    tag2.kx <= tag1.kx;
    off_q   <= off_full[ADDR_W-1:0];
  end

  // stage 3: wrap around the circular store
  always_comb begin
    pos = $signed({2'b00, geom.base}) + off_q;
    if (pos < 0) begin
      wrapped = pos + DEPTH_S;
    end else if (pos >= DEPTH_S) begin
      wrapped = pos - DEPTH_S;
    end else begin
      wrapped = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag2.valid;
    end
    tag_out.ky <= tag2.ky;
    tag_out.kx <= tag2.kx;
    addr       <= wrapped[ADDR_W-1:0];
  end
endmodule

// ----- design/gab_tap_cell.sv -----
// ----------------------------------------------------------------------------
// gab_tap_cell
// One column of the window: adds its weighted pixel to the passing row sum.
// ----------------------------------------------------------------------------
module gab_tap_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gab_pkg::KIDX_W-1:0] col_index,
  input  logic [gab_pkg::KIDX_W-1:0] ky,
  input  logic [gab_pkg::PIX_W-1:0]  pix,
  input  logic [gab_pkg::ROW_W-1:0]  psum_in,
  input  logic                       token_in,
  output logic [gab_pkg::ROW_W-1:0]  psum_out,
  output logic                       token_out
);
  import gab_pkg::*;

  logic [WT_W-1:0]       weight;
  logic [WT_W+PIX_W-1:0] prod;

  assign weight = weight_at({ky, col_index});
  assign prod   = weight * pix;

  // hand the row sum on to the next column
  always_ff @(posedge clk) begin
    if (rst) begin
      token_out <= 1'b0;
    end else begin
      token_out <= token_in;
    end
    psum_out <= psum_in + ROW_W'(prod);
  end
endmodule

// ----- design/gab_window_sum.sv -----
// ----------------------------------------------------------------------------
// gab_window_sum
// Chain of column cells forming row sums, and the window accumulator.
// ----------------------------------------------------------------------------
module gab_window_sum (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  gab_pkg::tap_tag_t         tag,
  input  logic [gab_pkg::PIX_W-1:0] pix,
  output gab_pkg::wsum_t            wsum
);
  import gab_pkg::*;

  logic [ROW_W-1:0]  psum_chain [WINDOW+1];
  logic              token_chain [WINDOW+1];
  logic [KIDX_W-1:0] rows;
  logic [SUM_W-1:0]  acc;
  logic [PIX_W-1:0]  centre;
  logic              done;

  // a row sum starts at the first column of each row
  assign psum_chain[0]  = '0;
  assign token_chain[0] = tag.valid && (tag.kx == '0);

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    gab_tap_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .col_index (KIDX_W'(k)),
      .ky        (tag.ky),
      .pix       (pix),
      .psum_in   (psum_chain[k]),
      .token_in  (token_chain[k]),
      .psum_out  (psum_chain[k+1]),
      .token_out (token_chain[k+1])
    );
  end

  // count finished rows, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rows <= '0;
      end else if (token_chain[WINDOW]) begin
        rows <= (rows == KIDX_W'(WINDOW - 1)) ? '0 : rows + 1'b1;
        done <= (rows == KIDX_W'(WINDOW - 1));
      end
    end
  end

  // accumulate row sums
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (token_chain[WINDOW]) begin
      acc <= acc + SUM_W'(psum_chain[WINDOW]);
    end
  end

  // capture the centre pixel as it passes
  always_ff @(posedge clk) begin
    if (tag.valid && tag.ky == KIDX_W'(HALF) && tag.kx == KIDX_W'(HALF)) begin
      centre <= pix;
    end
  end

  assign wsum.done   = done;
  assign wsum.sum    = acc;
  assign wsum.centre = centre;
endmodule

// ----- design/gaussian_adaptive_binarizer_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_adaptive_binarizer_unit
// Binarizes luma pixels against a 15x15 Gaussian-weighted local sum.
// ----------------------------------------------------------------------------
// A beat that yields no result leaves the unit idle. A beat that yields a result
// issues 225 tap reads, one a cycle through the single read port of the line
// store, then passes 4 address/read stages, the last column cell, the
// accumulator, the decision and the output register. The next beat is taken
// once the decision enters the output register, later while the result stalls.
// Reset is synchronous: counters clear, size registers return to 512, store kept.
module gaussian_adaptive_binarizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  gab_pixel_if.sink                     pixel,
  gab_level_if.source                   result,
  input  logic                          cfg_we,
  input  logic [gab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gab_pkg::SIDE_W-1:0]    cfg_data
);
  import gab_pkg::*;

  gab_state_t        state;
  gab_state_t        state_next;
  logic [SIDE_W-1:0] image_width;
  logic [SIDE_W-1:0] image_height;
  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  arrived;
  logic [CNT_W-1:0]  emit_bound;
  logic [EMIT_W-1:0] emitted;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] base;
  logic [POS_W-1:0]  row_pos;
  logic [POS_W-1:0]  col_pos;
  logic [LAG_W-1:0]  lag;
  logic              beat;
  logic              full;
  logic              restart;
  logic              store_now;
  logic              emit_now;
  logic              last_out;
  logic              advance;
  logic              scan_done;
  logic              out_load;
  logic [KIDX_W-1:0] ky;
  logic [KIDX_W-1:0] kx;
  tap_tag_t          scan_tag;
  tap_tag_t          addr_tag;
  tap_tag_t          rd_tag;
  geom_t             geom;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  wsum_t             wsum;
  logic [PIX_W-1:0]  pend_level;
  logic              pend_end;
  logic              out_valid;
  logic [PIX_W-1:0]  out_level;
  logic              out_end;

  // frame geometry
  assign w_eff      = clamp_side(image_width, SIDE_W'(MAX_WIDTH));
  assign h_eff      = clamp_side(image_height, SIDE_W'(MAX_HEIGHT));
  assign total      = CNT_W'(w_eff) * CNT_W'(h_eff);
  assign lag        = LAG_W'(32'(w_eff) * HALF + HALF);
  assign emit_bound = CNT_W'(emitted) + CNT_W'(lag);

  // input beat decode
  assign pixel.ready = (state == ST_IDLE);
  assign beat        = pixel.valid && pixel.ready;
  assign full        = (arrived >= total);
  assign store_now   = beat && !full && (pixel.kind == KIND_PIXEL);
  assign emit_now    = beat && (full || (store_now && (arrived + 1'b1 > emit_bound)));
  assign restart     = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign last_out    = (CNT_W'(emitted) + 1'b1 >= total);
  assign advance     = (state == ST_DRAIN) && wsum.done;
  assign scan_done   = (ky == KIDX_W'(WINDOW - 1)) && (kx == KIDX_W'(WINDOW - 1));
  assign out_load    = (state == ST_HOLD) && (!out_valid || result.ready);

  // size registers and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIDE_W'(RESET_SIDE);
      image_height <= SIDE_W'(RESET_SIDE);
      arrived      <= '0;
      wr_addr      <= '0;
      emitted      <= '0;
      base         <= '0;
      row_pos      <= '0;
      col_pos      <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_HEIGHT) begin
        image_height <= cfg_data;
      end
      if (restart || (advance && last_out)) begin
        arrived <= '0;
        wr_addr <= '0;
        emitted <= '0;
        base    <= '0;
        row_pos <= '0;
        col_pos <= '0;
      end else begin
        if (store_now) begin
          arrived <= arrived + 1'b1;
          wr_addr <= (wr_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_addr + 1'b1;
        end
        if (advance) begin
          emitted <= emitted + 1'b1;
          base    <= (base == ADDR_W'(STORE_DEPTH - 1)) ? '0 : base + 1'b1;
          if (col_pos == POS_W'(w_eff - 1'b1)) begin
            col_pos <= '0;
            row_pos <= row_pos + 1'b1;
          end else begin
            col_pos <= col_pos + 1'b1;
          end
        end
      end
    end
  end

  // tap scan counters
  always_ff @(posedge clk) begin
    if (emit_now) begin
      ky <= '0;
      kx <= '0;
    end else if (state == ST_SCAN) begin
      if (kx == KIDX_W'(WINDOW - 1)) begin
        kx <= '0;
        ky <= ky + 1'b1;
      end else begin
        kx <= kx + 1'b1;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (emit_now) state_next = ST_SCAN;
      ST_SCAN:  if (scan_done) state_next = ST_DRAIN;
      ST_DRAIN: if (wsum.done) state_next = ST_HOLD;
      ST_HOLD:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign scan_tag.valid = (state == ST_SCAN);
  assign scan_tag.ky    = ky;
  assign scan_tag.kx    = kx;

  assign geom.row_pos  = row_pos;
  assign geom.col_pos  = col_pos;
  assign geom.rem_rows = h_eff - 1'b1 - SIDE_W'(row_pos);
  assign geom.rem_cols = w_eff - 1'b1 - SIDE_W'(col_pos);
  assign geom.w_eff    = w_eff;
  assign geom.base     = base;

  gab_tap_addr u_addr (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (scan_tag),
    .geom    (geom),
    .tag_out (addr_tag),
    .addr    (rd_addr)
  );

  gab_line_store u_store (
    .clk   (clk),
    .we    (store_now),
    .waddr (wr_addr),
    .wdata (pixel.luma),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // align the tag with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= addr_tag.valid;
    end
    rd_tag.ky <= addr_tag.ky;
    rd_tag.kx <= addr_tag.kx;
  end

  gab_window_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .start (emit_now),
    .tag   (rd_tag),
    .pix   (rd_data),
    .wsum  (wsum)
  );

  // hold the finished decision until the output stage is free
  always_ff @(posedge clk) begin
    if (advance) begin
      pend_level <= (wsum.sum < SUM_W'({wsum.centre, 16'h0000})) ? WHITE : BLACK;
      pend_end   <= last_out;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_level <= pend_level;
      out_end   <= pend_end;
    end
  end

  assign result.valid     = out_valid;
  assign result.level     = out_level;
  assign result.frame_end = out_end;

  // checks
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    wsum.done |-> state == ST_DRAIN)
    else $error("window sum finished outside drain");

  a_idle_no_reads: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !rd_tag.valid)
    else $error("tap read in flight while idle");

  a_arrived_bound: assert property (@(posedge clk) disable iff (rst)
    arrived <= total)
    else $error("more pixels stored than the frame holds");

  a_emitted_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(emitted) < total)
    else $error("output count past end of frame");
endmodule
